// ===== rtl/pcli_pkg.sv =====
// ----------------------------------------------------------------------------
// pcli_pkg
// Types and constants shared by the patch code line interpreter.
// ----------------------------------------------------------------------------
package pcli_pkg;

    // Status codes carried in the result beat
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_WRITE      = 4'd1;
    localparam logic [3:0] ST_COUNT      = 4'd2;
    localparam logic [3:0] ST_OPCODE     = 4'd3;
    localparam logic [3:0] ST_ORDER      = 4'd4;
    localparam logic [3:0] ST_SIZE       = 4'd5;
    localparam logic [3:0] ST_RESERVED   = 4'd6;
    localparam logic [3:0] ST_RANGE      = 4'd7;
    localparam logic [3:0] ST_UNFINISHED = 4'd8;
    localparam logic [3:0] ST_FAILED     = 4'd9;

    // Opcode match patterns on the first code word
    localparam logic [31:0] MASK_WIDE  = 32'hF0FF_0000;
    localparam logic [31:0] MASK_SET   = 32'hFFFF_0000;
    localparam logic [31:0] OP_DIRECT  = 32'h0007_0000;
    localparam logic [31:0] OP_SET_OFS = 32'h4007_0000;
    localparam logic [31:0] OP_VALUE   = 32'h600F_0000;

    // Word counts a line may carry
    localparam logic [3:0] CNT_SHORT = 4'd3;
    localparam logic [3:0] CNT_LONG  = 4'd4;

    // Legal value sizes in bytes
    localparam logic [3:0] SZ_1 = 4'd1;
    localparam logic [3:0] SZ_2 = 4'd2;
    localparam logic [3:0] SZ_4 = 4'd4;
    localparam logic [3:0] SZ_8 = 4'd8;

    typedef struct packed {
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [3:0]  word_count;
        logic        last_line;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic        write_valid;
        logic [31:0] write_offset;
        logic [63:0] write_data;
        logic [3:0]  write_bytes;
        logic        list_ok;
    } t_out_item;

    // Pending set-offset state carried between lines
    typedef struct packed {
        logic        offset_pending;
        logic [31:0] held_offset;
    } t_line_state;

    // Decode outcome: next pending state and sticky failure
    typedef struct packed {
        t_line_state line;
        logic        failed;
    } t_step;

endpackage

// ===== rtl/pcli_in_stage.sv =====
// ----------------------------------------------------------------------------
// pcli_in_stage
// Input register: captures one line beat and holds it until decode advances.
// ----------------------------------------------------------------------------
module pcli_in_stage
    import pcli_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_advance,
    output logic     o_vld,
    output t_in_item o_item
);

    logic     r_vld;
    logic     n_vld;
    t_in_item r_item;
    logic     take;

    // Stall only when the held beat cannot move on this cycle
    assign o_in_stall = r_vld && !i_advance;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        n_vld = r_vld;
        if (take) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_in_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/pcli_decode.sv =====
// ----------------------------------------------------------------------------
// pcli_decode
// Line decode: opcode and size checks, ordering, range check, write build.
// ----------------------------------------------------------------------------
module pcli_decode
    import pcli_pkg::*;
(
    input  t_in_item    i_item,
    input  t_line_state i_state,
    input  logic        i_failed,
    input  logic [31:0] i_image_size,
    output t_out_item   o_result,
    output t_step       o_next
);

    logic [3:0]  size;
    logic        cnt_ok;
    logic        size_ok;
    logic        cnt_size_ok;
    logic [3:0]  value_err;
    logic        op_direct;
    logic        op_set;
    logic        op_value;
    logic [31:0] off_sel;
    logic [32:0] end_sum;
    logic        range_bad;
    logic [3:0]  err;
    logic        wr;
    logic        set_ok;
    logic [63:0] data_mask;
    logic [3:0]  status;

    // Field decode
    assign size      = i_item.word_a[27:24];
    assign cnt_ok    = (i_item.word_count == CNT_SHORT) || (i_item.word_count == CNT_LONG);
    assign op_direct = (i_item.word_a & MASK_WIDE) == OP_DIRECT;
    assign op_set    = (i_item.word_a & MASK_SET) == OP_SET_OFS;
    assign op_value  = (i_item.word_a & MASK_WIDE) == OP_VALUE;

    assign size_ok     = (size == SZ_1) || (size == SZ_2) || (size == SZ_4) || (size == SZ_8);
    assign cnt_size_ok = (size == SZ_8) ? (i_item.word_count == CNT_LONG)
                                        : (i_item.word_count == CNT_SHORT);
    assign value_err   = !size_ok ? ST_SIZE : (!cnt_size_ok ? ST_COUNT : ST_OK);

    // Bounds check without 32-bit wrap
    assign off_sel   = op_direct ? i_item.word_b : i_state.held_offset;
    assign end_sum   = {1'b0, off_sel} + {29'd0, size};
    assign range_bad = end_sum > {1'b0, i_image_size};

    // Error priority follows the line checks in order
    always_comb begin
        err    = ST_OK;
        wr     = 1'b0;
        set_ok = 1'b0;
        priority if (!cnt_ok) begin
            err = ST_COUNT;
        end else if (op_direct) begin
            if (i_state.offset_pending) begin
                err = ST_ORDER;
            end else if (value_err != ST_OK) begin
                err = value_err;
            end else if (range_bad) begin
                err = ST_RANGE;
            end else begin
                wr = 1'b1;
            end
        end else if (op_set) begin
            if (i_state.offset_pending) begin
                err = ST_ORDER;
            end else if (i_item.word_count != CNT_SHORT) begin
                err = ST_COUNT;
            end else if (i_item.word_b != 32'd0) begin
                err = ST_RESERVED;
            end else begin
                set_ok = 1'b1;
            end
        end else if (op_value) begin
            if (!i_state.offset_pending) begin
                err = ST_ORDER;
            end else if (value_err != ST_OK) begin
                err = value_err;
            end else if (range_bad) begin
                err = ST_RANGE;
            end else begin
                wr = 1'b1;
            end
        end else begin
            err = ST_OPCODE;
        end
    end

    // Keep only the low bytes of the value
    always_comb begin
        unique case (size)
            SZ_1:    data_mask = 64'h0000_0000_0000_00FF;
            SZ_2:    data_mask = 64'h0000_0000_0000_FFFF;
            SZ_4:    data_mask = 64'h0000_0000_FFFF_FFFF;
            default: data_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    end

    // Status and result beat
    always_comb begin
        if (i_failed) begin
            status = ST_FAILED;
        end else if (err != ST_OK) begin
            status = err;
        end else if (wr) begin
            status = ST_WRITE;
        end else if (set_ok && i_item.last_line) begin
            status = ST_UNFINISHED;
        end else begin
            status = ST_OK;
        end

        o_result              = '0;
        o_result.status       = status;
        o_result.list_ok      = i_item.last_line && ((status == ST_OK) || (status == ST_WRITE));
        if (!i_failed && wr) begin
            o_result.write_valid  = 1'b1;
            o_result.write_offset = off_sel;
            o_result.write_bytes  = size;
            o_result.write_data   = (size == SZ_8) ? {i_item.word_c, i_item.word_d}
                                                   : ({32'd0, i_item.word_c} & data_mask);
        end
    end

    // Next pending state; errors leave it untouched
    always_comb begin
        o_next.line   = i_state;
        o_next.failed = i_failed || (err != ST_OK) || (set_ok && i_item.last_line);
        if (!i_failed && (err == ST_OK)) begin
            if (wr) begin
                o_next.line.offset_pending = 1'b0;
                o_next.line.held_offset    = 32'd0;
            end else if (set_ok) begin
                o_next.line.offset_pending = 1'b1;
                o_next.line.held_offset    = i_item.word_c;
            end
        end
    end

endmodule

// ===== rtl/patch_code_line_interpreter_unit.sv =====
// ----------------------------------------------------------------------------
// patch_code_line_interpreter_unit
// Decodes patch lines into write commands with sticky errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one beat per patch
//   line. Output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result beat per line, in order, carrying status and an optional write.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): image size in
//   bytes; always ready, write it only while no line is in flight.
//   A line taken sits in the input register; its result is loaded into the
//   output register when decode advances, and o_out_valid then rises.
//   Throughput: one line per cycle while the receiver does not stall. The
//   limit is the pending-offset and failure state, read and updated per line.
//   Receiver stall: the result holds in the output register while one more
//   line waits in the input register; only then is o_in_stall raised.
//   Reset: clears both valid flags, the pending offset, the sticky failure
//   flag and the image size (zero, so every write is out of range).
// ----------------------------------------------------------------------------
module patch_code_line_interpreter_unit
    import pcli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        stg_vld;
    t_in_item    stg_item;
    logic        advance;
    t_out_item   dec_result;
    t_step       dec_next;

    logic [31:0] r_image_size;
    t_line_state r_state;
    logic        r_failed;
    logic        r_out_vld;
    logic        n_out_vld;
    t_out_item   r_out_item;

    // Decode advances whenever the output register is free or draining
    assign advance = stg_vld && !(r_out_vld && i_out_stall);

    pcli_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_advance  (advance),
        .o_vld      (stg_vld),
        .o_item     (stg_item)
    );

    pcli_decode u_decode (
        .i_item       (stg_item),
        .i_state      (r_state),
        .i_failed     (r_failed),
        .i_image_size (r_image_size),
        .o_result     (dec_result),
        .o_next       (dec_next)
    );

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_image_size <= i_cfg_data;
        end
    end

    // Pending state and sticky failure update once per decoded line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_failed <= 1'b0;
        end else if (advance) begin
            r_state  <= dec_next.line;
            r_failed <= dec_next.failed;
        end
    end

    // Output register
    always_comb begin
        n_out_vld = r_out_vld;
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= dec_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Checks
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.write_valid |-> o_out_item.status == ST_WRITE)
        else $error("write issued with non-write status");

    a_write_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.write_valid |->
            (o_out_item.write_bytes == SZ_1) || (o_out_item.write_bytes == SZ_2) ||
            (o_out_item.write_bytes == SZ_4) || (o_out_item.write_bytes == SZ_8))
        else $error("write with illegal byte count");

    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed && advance |=> o_out_valid && o_out_item.status == ST_FAILED
            && !o_out_item.write_valid && r_failed)
        else $error("line after failure not reported as failed");

    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.list_ok |->
            (o_out_item.status == ST_OK) || (o_out_item.status == ST_WRITE))
        else $error("list_ok raised on error status");

endmodule
